// ----- rtl/gamepad_to_console_pad_translate_assert.svh -----
// assertion macros for the gamepad to console pad translator
`ifndef GAMEPAD_TO_CONSOLE_PAD_TRANSLATE_ASSERT_SVH
`define GAMEPAD_TO_CONSOLE_PAD_TRANSLATE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GPCT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gpct same-cycle check failed");

// next-cycle implication, checked out of reset
`define GPCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gpct next-cycle check failed");

`endif

// ----- rtl/gpct_pkg.sv -----
// shared types, constants and axis scaling functions for the pad translator
package gpct_pkg;

	localparam logic [7:0]  CENTRE          = 8'd128;
	localparam logic [7:0]  TRIG_FULL       = 8'd255;
	localparam logic [15:0] PAD_NONE        = 16'hFFFF;
	localparam logic [7:0]  TRIG_THRESH_RST = 8'd30;
	localparam logic [15:0] LEFT_DZ_RST     = 16'd7849;
	localparam logic [15:0] RIGHT_DZ_RST    = 16'd8689;
	localparam logic [31:0] LEFT_DZ_SQ_RST  = 32'(LEFT_DZ_RST) * 32'(LEFT_DZ_RST);
	localparam logic [31:0] RIGHT_DZ_SQ_RST = 32'(RIGHT_DZ_RST) * 32'(RIGHT_DZ_RST);
	localparam logic [15:0] FULL_SCALE      = 16'd32767;

	typedef enum logic [1:0] {
		REG_EXT_MODE    = 2'd0,
		REG_TRIG_THRESH = 2'd1,
		REG_LEFT_DZ     = 2'd2,
		REG_RIGHT_DZ    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
	} stick_pos_t;

	// magnitude of a signed axis, full negative gives 0x8000
	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		logic [15:0] m;
		m = v[15] ? 16'(-v) : 16'(v);
		return m;
	endfunction

	// floor(num / 32767) for num up to 32767 * 128
	function automatic logic [7:0] div_full_scale(input logic [21:0] num);
		logic [7:0]  q0;
		logic [15:0] r;
		q0 = {1'b0, num[21:15]};
		r  = {1'b0, num[14:0]} + {8'd0, q0};
		return (r >= FULL_SCALE) ? 8'(q0 + 8'd1) : q0;
	endfunction

	// horizontal axis: right positive maps above centre
	function automatic logic [7:0] scale_x(input logic signed [15:0] v);
		logic [15:0] m;
		logic [21:0] num;
		logic [8:0]  res;
		m   = mag16(v);
		// m * 127 for the positive side
		num = {m[14:0], 7'd0} - {6'd0, m};
		if (v[15])
			res = {1'b0, CENTRE} - {1'b0, m[15:8]};
		else
			res = {1'b0, CENTRE} + {1'b0, div_full_scale(num)};
		return res[7:0];
	endfunction

	// vertical axis: inverted so that up maps to 0
	function automatic logic [7:0] scale_y(input logic signed [15:0] v);
		logic [15:0] m;
		logic [22:0] num_n;
		logic [21:0] num_p;
		logic [8:0]  res;
		m     = mag16(v);
		num_n = {m, 7'd0} - {7'd0, m};
		num_p = {m[14:0], 7'd0};
		if (v[15])
			res = {1'b0, CENTRE} + {1'b0, num_n[22:15]};
		else
			res = {1'b0, CENTRE} - {1'b0, div_full_scale(num_p)};
		return res[7:0];
	endfunction

endpackage

// ----- rtl/gpct_stick.sv -----
// one analog stick: squares and scaled axes registered, then deadzone select
module gpct_stick (
	input  logic                    clk,
	input  logic                    load,
	input  logic signed [15:0]      x,
	input  logic signed [15:0]      y,
	input  logic [31:0]             dz_sq,
	output gpct_pkg::stick_pos_t    pos
);
	import gpct_pkg::*;

	logic [15:0] mag_x;
	logic [15:0] mag_y;
	logic [31:0] sq_x_s2;
	logic [31:0] sq_y_s2;
	logic [7:0]  sx_s2;
	logic [7:0]  sy_s2;
	logic [32:0] sq_sum;
	logic        in_dz;

	assign mag_x = mag16(x);
	assign mag_y = mag16(y);

	always_ff @(posedge clk) begin
		if (load) begin
			sq_x_s2 <= mag_x * mag_x;
			sq_y_s2 <= mag_y * mag_y;
			sx_s2   <= scale_x(x);
			sy_s2   <= scale_y(y);
		end
	end

	assign sq_sum = {1'b0, sq_x_s2} + {1'b0, sq_y_s2};
	assign in_dz  = sq_sum < {1'b0, dz_sq};

	always_comb begin
		pos.x = in_dz ? CENTRE : sx_s2;
		pos.y = in_dz ? CENTRE : sy_s2;
	end

endmodule

// ----- rtl/gamepad_to_console_pad_translate.sv -----
// top level of the gamepad report to console pad translator
// Takes one gamepad report per request and returns one console pad condition per
// request, in order. The block is a three-register pipeline: input register, a stage
// holding the squared stick radii and the scaled axes, and the result register. A
// request is accepted every cycle while the output side keeps up; a request passes the
// input, middle and result registers before out_valid rises, and the stick multipliers
// are registered before the deadzone add and compare. Each stage stalls only when the
// one after it is full and not moving on, so bubbles behind a waiting result are filled
// before the input side stalls. The squared deadzone radii follow configuration writes
// in the next cycle, so writes should be done while the pipeline is empty.
module gamepad_to_console_pad_translate (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// report request
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        pad_buttons,
	input  logic [7:0]         left_trig_in,
	input  logic [7:0]         right_trig_in,
	input  logic signed [15:0] lstick_x,
	input  logic signed [15:0] lstick_y,
	input  logic signed [15:0] rstick_x,
	input  logic signed [15:0] rstick_y,
	// pad condition request
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        pad_word,
	output logic [7:0]         right_trig_out,
	output logic [7:0]         left_trig_out,
	output logic [7:0]         main_x,
	output logic [7:0]         main_y,
	output logic [7:0]         second_x,
	output logic [7:0]         second_y
);
	import gpct_pkg::*;

	`include "gamepad_to_console_pad_translate_assert.svh"

	// gamepad button bits (active high)
	localparam int unsigned IN_UP    = 0;
	localparam int unsigned IN_DOWN  = 1;
	localparam int unsigned IN_LEFT  = 2;
	localparam int unsigned IN_RIGHT = 3;
	localparam int unsigned IN_START = 4;
	localparam int unsigned IN_BACK  = 5;
	localparam int unsigned IN_LSHLD = 8;
	localparam int unsigned IN_RSHLD = 9;
	localparam int unsigned IN_A     = 12;
	localparam int unsigned IN_B     = 13;
	localparam int unsigned IN_X     = 14;
	localparam int unsigned IN_Y     = 15;

	// console pad bits (active low)
	localparam int unsigned OUT_C     = 0;
	localparam int unsigned OUT_B     = 1;
	localparam int unsigned OUT_A     = 2;
	localparam int unsigned OUT_START = 3;
	localparam int unsigned OUT_UP    = 4;
	localparam int unsigned OUT_DOWN  = 5;
	localparam int unsigned OUT_LEFT  = 6;
	localparam int unsigned OUT_RIGHT = 7;
	localparam int unsigned OUT_Z     = 8;
	localparam int unsigned OUT_Y     = 9;
	localparam int unsigned OUT_X     = 10;
	localparam int unsigned OUT_D     = 11;

	// configuration registers
	logic        ext_mode_q;
	logic [7:0]  trig_thresh_q;
	logic [15:0] left_dz_q;
	logic [15:0] right_dz_q;
	logic [31:0] left_dz_sq_q;
	logic [31:0] right_dz_sq_q;

	// pipeline occupancy
	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic load1;
	logic load2;
	logic load3;

	// stage 1 payload
	logic [15:0]        btn_s1;
	logic [7:0]         lt_s1;
	logic [7:0]         rt_s1;
	logic signed [15:0] lx_s1;
	logic signed [15:0] ly_s1;
	logic signed [15:0] rx_s1;
	logic signed [15:0] ry_s1;

	// stage 2 payload
	logic [15:0] word_s2;
	logic [7:0]  lt_s2;
	logic [7:0]  rt_s2;

	// result register
	logic [15:0] word_q;
	logic [7:0]  lt_q;
	logic [7:0]  rt_q;
	logic [7:0]  main_x_q;
	logic [7:0]  main_y_q;
	logic [7:0]  second_x_q;
	logic [7:0]  second_y_q;

	logic [15:0] word_c;
	logic [7:0]  lt_c;
	logic [7:0]  rt_c;
	stick_pos_t  lpos;
	stick_pos_t  rpos;

	// standard mode result and what it must look like
	logic std_res;
	logic std_quiet;

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_mode_q    <= 1'b0;
			trig_thresh_q <= TRIG_THRESH_RST;
			left_dz_q     <= LEFT_DZ_RST;
			right_dz_q    <= RIGHT_DZ_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EXT_MODE:    ext_mode_q    <= cfg_data[0];
				REG_TRIG_THRESH: trig_thresh_q <= cfg_data[7:0];
				REG_LEFT_DZ:     left_dz_q     <= cfg_data;
				REG_RIGHT_DZ:    right_dz_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// squared deadzone radii, registered from the radius registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_sq_q  <= LEFT_DZ_SQ_RST;
			right_dz_sq_q <= RIGHT_DZ_SQ_RST;
		end else begin
			left_dz_sq_q  <= left_dz_q * left_dz_q;
			right_dz_sq_q <= right_dz_q * right_dz_q;
		end
	end

	// each stage takes new data when it is empty or the next one moves on
	assign rdy3     = !v3_q || out_ready;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;
	assign load1    = rdy1 && in_valid;
	assign load2    = rdy2 && v1_q;
	assign load3    = rdy3 && v2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1)
				v1_q <= in_valid;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy3)
				v3_q <= v2_q;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (load1) begin
			btn_s1 <= pad_buttons;
			lt_s1  <= left_trig_in;
			rt_s1  <= right_trig_in;
			lx_s1  <= lstick_x;
			ly_s1  <= lstick_y;
			rx_s1  <= rstick_x;
			ry_s1  <= rstick_y;
		end
	end

	// button remap and trigger threshold
	always_comb begin
		word_c = PAD_NONE;
		lt_c   = (lt_s1 < trig_thresh_q) ? 8'd0 : lt_s1;
		rt_c   = (rt_s1 < trig_thresh_q) ? 8'd0 : rt_s1;
		if (btn_s1[IN_A])     word_c[OUT_A]     = 1'b0;
		if (btn_s1[IN_B])     word_c[OUT_B]     = 1'b0;
		if (btn_s1[IN_X])     word_c[OUT_X]     = 1'b0;
		if (btn_s1[IN_Y])     word_c[OUT_Y]     = 1'b0;
		if (btn_s1[IN_START]) word_c[OUT_START] = 1'b0;
		if (btn_s1[IN_UP])    word_c[OUT_UP]    = 1'b0;
		if (btn_s1[IN_DOWN])  word_c[OUT_DOWN]  = 1'b0;
		if (btn_s1[IN_LEFT])  word_c[OUT_LEFT]  = 1'b0;
		if (btn_s1[IN_RIGHT]) word_c[OUT_RIGHT] = 1'b0;
		if (ext_mode_q) begin
			// shoulders and back become z, c and d
			if (btn_s1[IN_LSHLD]) word_c[OUT_Z] = 1'b0;
			if (btn_s1[IN_RSHLD]) word_c[OUT_C] = 1'b0;
			if (btn_s1[IN_BACK])  word_c[OUT_D] = 1'b0;
		end else begin
			// shoulders pull the triggers fully in
			if (btn_s1[IN_LSHLD]) lt_c = TRIG_FULL;
			if (btn_s1[IN_RSHLD]) rt_c = TRIG_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			word_s2 <= word_c;
			lt_s2   <= lt_c;
			rt_s2   <= rt_c;
		end
	end

	// sticks: stage 2 registers live inside, deadzone select comes out
	gpct_stick u_left_stick (
		.clk   (clk),
		.load  (load2),
		.x     (lx_s1),
		.y     (ly_s1),
		.dz_sq (left_dz_sq_q),
		.pos   (lpos)
	);

	gpct_stick u_right_stick (
		.clk   (clk),
		.load  (load2),
		.x     (rx_s1),
		.y     (ry_s1),
		.dz_sq (right_dz_sq_q),
		.pos   (rpos)
	);

	// result register, second stick stays centred in standard mode
	always_ff @(posedge clk) begin
		if (load3) begin
			word_q     <= word_s2;
			lt_q       <= lt_s2;
			rt_q       <= rt_s2;
			main_x_q   <= lpos.x;
			main_y_q   <= lpos.y;
			second_x_q <= ext_mode_q ? rpos.x : CENTRE;
			second_y_q <= ext_mode_q ? rpos.y : CENTRE;
		end
	end

	assign out_valid      = v3_q;
	assign pad_word       = word_q;
	assign right_trig_out = rt_q;
	assign left_trig_out  = lt_q;
	assign main_x         = main_x_q;
	assign main_y         = main_y_q;
	assign second_x       = second_x_q;
	assign second_y       = second_y_q;

	assign std_res   = out_valid && !ext_mode_q;
	assign std_quiet = second_x == CENTRE && second_y == CENTRE && pad_word[OUT_Z]
		&& pad_word[OUT_D];

	// a pipeline with a free slot must take a request
	`GPCT_ASSERT_SAME(a_ready_when_room, !(v1_q && v2_q && v3_q), in_ready)
	// a full middle stage moves into a free result register
	`GPCT_ASSERT_NEXT(a_mid_handover, v2_q && rdy3, v3_q)
	// standard mode keeps the second stick centred and the z and d buttons released
	`GPCT_ASSERT_SAME(a_std_mode_out, std_res && $stable(ext_mode_q), std_quiet)

endmodule

// ----- verif/gamepad_to_console_pad_translate_checker.sv -----
// checker for the pad translator: predicts each pad condition and compares it with the block
module gamepad_to_console_pad_translate_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  gpct_pkg::cfg_reg_t   cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [15:0]          pad_buttons,
	input  logic [7:0]           left_trig_in,
	input  logic [7:0]           right_trig_in,
	input  logic signed [15:0]   lstick_x,
	input  logic signed [15:0]   lstick_y,
	input  logic signed [15:0]   rstick_x,
	input  logic signed [15:0]   rstick_y,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [15:0]          pad_word,
	input  logic [7:0]           right_trig_out,
	input  logic [7:0]           left_trig_out,
	input  logic [7:0]           main_x,
	input  logic [7:0]           main_y,
	input  logic [7:0]           second_x,
	input  logic [7:0]           second_y,
	output int                   mismatches,
	output int                   pending,
	output int                   reports_seen,
	output int                   conds_seen
);
	import gpct_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// gamepad report button bits, active high
	localparam logic [15:0] BTN_UP    = 16'h0001;
	localparam logic [15:0] BTN_DOWN  = 16'h0002;
	localparam logic [15:0] BTN_LEFT  = 16'h0004;
	localparam logic [15:0] BTN_RIGHT = 16'h0008;
	localparam logic [15:0] BTN_START = 16'h0010;
	localparam logic [15:0] BTN_BACK  = 16'h0020;
	localparam logic [15:0] BTN_LSHLD = 16'h0100;
	localparam logic [15:0] BTN_RSHLD = 16'h0200;
	localparam logic [15:0] BTN_A     = 16'h1000;
	localparam logic [15:0] BTN_B     = 16'h2000;
	localparam logic [15:0] BTN_X     = 16'h4000;
	localparam logic [15:0] BTN_Y     = 16'h8000;

	// console pad word bits, active low
	localparam logic [15:0] COND_C     = 16'h0001;
	localparam logic [15:0] COND_B     = 16'h0002;
	localparam logic [15:0] COND_A     = 16'h0004;
	localparam logic [15:0] COND_START = 16'h0008;
	localparam logic [15:0] COND_UP    = 16'h0010;
	localparam logic [15:0] COND_DOWN  = 16'h0020;
	localparam logic [15:0] COND_LEFT  = 16'h0040;
	localparam logic [15:0] COND_RIGHT = 16'h0080;
	localparam logic [15:0] COND_Z     = 16'h0100;
	localparam logic [15:0] COND_Y     = 16'h0200;
	localparam logic [15:0] COND_X     = 16'h0400;
	localparam logic [15:0] COND_D     = 16'h0800;

	localparam logic [15:0] WORD_IDLE    = 16'hFFFF;
	localparam logic [7:0]  AXIS_CENTRE  = 8'd128;
	localparam logic [7:0]  TRIG_PINNED  = 8'd255;
	localparam logic [7:0]  THRESH_AT_RST = 8'd30;
	localparam logic [15:0] LDZ_AT_RST   = 16'd7849;
	localparam logic [15:0] RDZ_AT_RST   = 16'd8689;
	localparam int          REPORT_LIMIT = 10;

	typedef struct packed {
		logic [15:0] word;
		logic [7:0]  rtrig;
		logic [7:0]  ltrig;
		logic [7:0]  mx;
		logic [7:0]  my;
		logic [7:0]  sx;
		logic [7:0]  sy;
	} pad_cond_t;

	logic        ext_mode;
	logic [7:0]  trig_thresh;
	logic [15:0] left_dz;
	logic [15:0] right_dz;

	pad_cond_t expected_conds[$];

	function automatic bit beyond_deadzone(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic [15:0] radius);
		longint ax;
		longint ay;
		longint r;
		ax = (x < 0) ? -longint'(x) : longint'(x);
		ay = (y < 0) ? -longint'(y) : longint'(y);
		r  = longint'(radius);
		return !((ax * ax + ay * ay) < (r * r));
	endfunction

	// vertical axes are inverted so that up reads 0
	function automatic logic [7:0] axis_to_byte(input logic signed [15:0] v, input bit vertical);
		int m;
		int r;
		m = (v < 0) ? -int'(v) : int'(v);
		if (!vertical)
			r = (v < 0) ? 128 - (m * 128) / 32768 : 128 + (m * 127) / 32767;
		else
			r = (v < 0) ? 128 + (m * 127) / 32768 : 128 - (m * 128) / 32767;
		return 8'(r);
	endfunction

	function automatic pad_cond_t translate_report(input logic [15:0] btn,
			input logic [7:0] lt_raw, input logic [7:0] rt_raw,
			input logic signed [15:0] lx, input logic signed [15:0] ly,
			input logic signed [15:0] rx, input logic signed [15:0] ry);
		pad_cond_t c;
		c.word  = WORD_IDLE;
		c.ltrig = (lt_raw < trig_thresh) ? 8'd0 : lt_raw;
		c.rtrig = (rt_raw < trig_thresh) ? 8'd0 : rt_raw;
		c.mx    = AXIS_CENTRE;
		c.my    = AXIS_CENTRE;
		c.sx    = AXIS_CENTRE;
		c.sy    = AXIS_CENTRE;
		if (beyond_deadzone(lx, ly, left_dz)) begin
			c.mx = axis_to_byte(lx, 1'b0);
			c.my = axis_to_byte(ly, 1'b1);
		end
		if ((btn & BTN_A) != 0)     c.word &= ~COND_A;
		if ((btn & BTN_B) != 0)     c.word &= ~COND_B;
		if ((btn & BTN_X) != 0)     c.word &= ~COND_X;
		if ((btn & BTN_Y) != 0)     c.word &= ~COND_Y;
		if ((btn & BTN_START) != 0) c.word &= ~COND_START;
		if ((btn & BTN_UP) != 0)    c.word &= ~COND_UP;
		if ((btn & BTN_DOWN) != 0)  c.word &= ~COND_DOWN;
		if ((btn & BTN_LEFT) != 0)  c.word &= ~COND_LEFT;
		if ((btn & BTN_RIGHT) != 0) c.word &= ~COND_RIGHT;
		if (ext_mode) begin
			if ((btn & BTN_LSHLD) != 0) c.word &= ~COND_Z;
			if ((btn & BTN_RSHLD) != 0) c.word &= ~COND_C;
			if ((btn & BTN_BACK) != 0)  c.word &= ~COND_D;
			if (beyond_deadzone(rx, ry, right_dz)) begin
				c.sx = axis_to_byte(rx, 1'b0);
				c.sy = axis_to_byte(ry, 1'b1);
			end
		end else begin
			if ((btn & BTN_LSHLD) != 0) c.ltrig = TRIG_PINNED;
			if ((btn & BTN_RSHLD) != 0) c.rtrig = TRIG_PINNED;
		end
		return c;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch on %s of condition %0d: expected 0x%0h, got 0x%0h",
					what, conds_seen, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pad_cond_t want;
		if (!arst_n) begin
			ext_mode     = 1'b0;
			trig_thresh  = THRESH_AT_RST;
			left_dz      = LDZ_AT_RST;
			right_dz     = RDZ_AT_RST;
			expected_conds.delete();
			mismatches   = 0;
			reports_seen = 0;
			conds_seen   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EXT_MODE:    ext_mode    = cfg_data[0];
					REG_TRIG_THRESH: trig_thresh = cfg_data[7:0];
					REG_LEFT_DZ:     left_dz     = cfg_data;
					REG_RIGHT_DZ:    right_dz    = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_conds.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("pad condition %0d arrived with nothing expected: word 0x%0h",
							conds_seen, pad_word);
				end else begin
					want = expected_conds.pop_front();
					check_field("pad_word", want.word, pad_word);
					check_field("right_trig_out", want.rtrig, right_trig_out);
					check_field("left_trig_out", want.ltrig, left_trig_out);
					check_field("main_x", want.mx, main_x);
					check_field("main_y", want.my, main_y);
					check_field("second_x", want.sx, second_x);
					check_field("second_y", want.sy, second_y);
				end
				conds_seen++;
			end
			if (in_valid && in_ready) begin
				expected_conds.push_back(translate_report(pad_buttons, left_trig_in, right_trig_in,
					lstick_x, lstick_y, rstick_x, rstick_y));
				reports_seen++;
			end
		end
		pending = expected_conds.size();
	end

endmodule

// ----- verif/gamepad_to_console_pad_translate_tb.sv -----
// testbench top for the pad translator: stimulus, handshake pressure and the final verdict
module gamepad_to_console_pad_translate_tb;
	import gpct_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// longest stretch with no request accepted on either side before giving up
	localparam int QUIET_LIMIT = 4000;
	// receiver hold-off, long enough to fill the pipeline and stall the input side
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 150;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	cfg_reg_t           cfg_index = REG_EXT_MODE;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        pad_buttons = '0;
	logic [7:0]         left_trig_in = '0;
	logic [7:0]         right_trig_in = '0;
	logic signed [15:0] lstick_x = '0;
	logic signed [15:0] lstick_y = '0;
	logic signed [15:0] rstick_x = '0;
	logic signed [15:0] rstick_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        pad_word;
	logic [7:0]         right_trig_out;
	logic [7:0]         left_trig_out;
	logic [7:0]         main_x;
	logic [7:0]         main_y;
	logic [7:0]         second_x;
	logic [7:0]         second_y;

	int mismatches;
	int pending;
	int reports_seen;
	int conds_seen;

	// random idling on both sides; cleared for one whole phase to get back-to-back traffic
	bit idle_on = 1'b1;
	// raised by the stimulus to ask the receiver for one long hold-off
	bit sink_hold_req = 1'b0;
	int quiet_cycles = 0;

	// register settings currently in force, used to aim stick and trigger values
	logic [7:0]  cur_thr = 8'd30;
	logic [15:0] cur_ldz = 16'd7849;
	logic [15:0] cur_rdz = 16'd8689;
	int          settings_used = 1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gamepad_to_console_pad_translate i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pad_buttons    (pad_buttons),
		.left_trig_in   (left_trig_in),
		.right_trig_in  (right_trig_in),
		.lstick_x       (lstick_x),
		.lstick_y       (lstick_y),
		.rstick_x       (rstick_x),
		.rstick_y       (rstick_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pad_word       (pad_word),
		.right_trig_out (right_trig_out),
		.left_trig_out  (left_trig_out),
		.main_x         (main_x),
		.main_y         (main_y),
		.second_x       (second_x),
		.second_y       (second_y)
	);

	gamepad_to_console_pad_translate_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pad_buttons    (pad_buttons),
		.left_trig_in   (left_trig_in),
		.right_trig_in  (right_trig_in),
		.lstick_x       (lstick_x),
		.lstick_y       (lstick_y),
		.rstick_x       (rstick_x),
		.rstick_y       (rstick_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pad_word       (pad_word),
		.right_trig_out (right_trig_out),
		.left_trig_out  (left_trig_out),
		.main_x         (main_x),
		.main_y         (main_y),
		.second_x       (second_x),
		.second_y       (second_y),
		.mismatches     (mismatches),
		.pending        (pending),
		.reports_seen   (reports_seen),
		.conds_seen     (conds_seen)
	);

	// watchdog: a hang shows up as a long run of cycles with no request moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("gamepad_to_console_pad_translate_tb failed");
			$finish;
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				out_ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				sink_hold_req = 1'b0;
			end
			out_ready <= !(idle_on && $urandom_range(99) < 9);
		end
	end

	// offer one report and hold it steady until the block takes it
	task automatic send_report(input logic [15:0] btn, input logic [7:0] lt, input logic [7:0] rt,
			input logic signed [15:0] lx, input logic signed [15:0] ly,
			input logic signed [15:0] rx, input logic signed [15:0] ry);
		in_valid      <= 1'b1;
		pad_buttons   <= btn;
		left_trig_in  <= lt;
		right_trig_in <= rt;
		lstick_x      <= lx;
		lstick_y      <= ly;
		rstick_x      <= rx;
		rstick_y      <= ry;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// stop sending and wait for every outstanding pad condition to come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// registers change only with the pipeline empty; the squared radii settle in the next cycle
	task automatic program_settings(input logic ext, input logic [7:0] thr,
			input logic [15:0] ldz, input logic [15:0] rdz);
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_EXT_MODE;
		cfg_data  <= 16'(ext);
		@(posedge clk);
		cfg_index <= REG_TRIG_THRESH;
		cfg_data  <= 16'(thr);
		@(posedge clk);
		cfg_index <= REG_LEFT_DZ;
		cfg_data  <= ldz;
		@(posedge clk);
		cfg_index <= REG_RIGHT_DZ;
		cfg_data  <= rdz;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
		cur_thr = thr;
		cur_ldz = ldz;
		cur_rdz = rdz;
		settings_used++;
	endtask

	// single axis: full range, the corners of the range, or small deflections
	function automatic logic signed [15:0] pick_axis();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(5))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return -16'sd32767;
					3: return 16'sd0;
					4: return 16'sd1;
					default: return -16'sd1;
				endcase
			end
			1: return 16'(int'($urandom_range(4000)) - 2000);
			default: return 16'($urandom);
		endcase
	endfunction

	// stick position: free, well inside the deadzone, or straddling its edge
	task automatic pick_stick(input logic [15:0] radius, output logic signed [15:0] x,
			output logic signed [15:0] y);
		int  xa;
		int  ya;
		int  cap;
		real rr;
		real xr;
		cap = (radius > 16'd32767) ? 32767 : int'(radius);
		case ($urandom_range(3))
			0: begin
				xa = $urandom_range(cap / 2);
				ya = $urandom_range(cap / 2);
			end
			1: begin
				// a point within a step or so of the circle, so the strict compare is exercised
				rr = real'(radius);
				xa = $urandom_range(cap);
				xr = real'(xa);
				ya = (rr * rr > xr * xr) ? int'($sqrt(rr * rr - xr * xr)) : 0;
				ya = ya + int'($urandom_range(2)) - 1;
				if (ya < 0)
					ya = 0;
				if (ya > 32767)
					ya = 32767;
				if ($urandom_range(1)) begin
					cap = xa;
					xa  = ya;
					ya  = cap;
				end
			end
			default: begin
				x = pick_axis();
				y = pick_axis();
				return;
			end
		endcase
		x = $urandom_range(1) ? 16'(-xa) : 16'(xa);
		y = $urandom_range(1) ? 16'(-ya) : 16'(ya);
	endtask

	// triggers cluster around the threshold and the ends of the range
	function automatic logic [7:0] pick_trig();
		case ($urandom_range(3))
			0: return 8'(int'(cur_thr) + int'($urandom_range(2)) - 1);
			1: return $urandom_range(1) ? 8'd255 : 8'd0;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_buttons();
		case ($urandom_range(7))
			0: return 16'h0001 << $urandom_range(15);
			1: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// random reports with source gaps; optional receiver hold-off and a full drain mid-phase
	task automatic run_random(input int n, input int hold_at, input int pause_at);
		logic [15:0]        btn;
		logic [7:0]         lt;
		logic [7:0]         rt;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		for (int k = 0; k < n; k++) begin
			if (k == hold_at)
				sink_hold_req = 1'b1;
			if (k == pause_at)
				drain();
			btn = pick_buttons();
			lt  = pick_trig();
			rt  = pick_trig();
			pick_stick(cur_ldz, lx, ly);
			pick_stick(cur_rdz, rx, ry);
			while (idle_on && $urandom_range(99) < 9) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			send_report(btn, lt, rt, lx, ly, rx, ry);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: standard mapping, threshold 30, deadzones 7849 and 8689
		send_report(16'h0000, 8'd0, 8'd0, 0, 0, 0, 0);
		send_report(16'hFFFF, 8'd255, 8'd255, 32767, 32767, -32768, -32768);
		// shoulders pin the triggers in standard mode
		send_report(16'h0300, 8'd0, 8'd0, -32768, -32768, 32767, 32767);
		send_report(16'h0100, 8'd29, 8'd30, -32768, 32767, 0, 0);
		send_report(16'h0200, 8'd30, 8'd29, 7848, 0, 0, 0);
		// radius equal to the deadzone is outside it
		send_report(16'h0011, 8'd0, 8'd255, 7849, 0, 0, 0);
		send_report(16'h3022, 8'd1, 8'd254, 0, -7849, 8689, 0);
		send_report(16'h4004, 8'd0, 8'd0, 5550, 5550, 0, 0);
		send_report(16'h8008, 8'd0, 8'd0, -5551, 5551, 0, 0);
		// unmapped button bits only
		send_report(16'h0CC0, 8'd31, 8'd30, 0, 0, 0, 0);

		// extended mapping, threshold zero and zero deadzones: triggers pass, sticks always scale
		program_settings(1'b1, 8'd0, 16'd0, 16'd0);
		send_report(16'h0000, 8'd0, 8'd0, 0, 0, 0, 0);
		send_report(16'h0320, 8'd5, 8'd0, 0, 0, -32768, -32768);
		send_report(16'hFFFF, 8'd255, 8'd1, 1, -1, 32767, -32767);
		send_report(16'h0100, 8'd0, 8'd0, -1, 1, -32767, 32767);

		// deadzones past full scale swallow every position
		program_settings(1'b1, 8'd255, 16'd65535, 16'd65535);
		send_report(16'h0200, 8'd254, 8'd255, 32767, 32767, -32768, -32768);
		send_report(16'h0020, 8'd255, 8'd254, -32768, 32767, 32767, -32768);

		// deadzone of exactly full scale
		program_settings(1'b1, 8'd128, 16'd32768, 16'd32768);
		send_report(16'h0000, 8'd127, 8'd128, -32768, 0, 0, -32768);
		send_report(16'hF33F, 8'd0, 8'd0, 32767, 0, 0, 32767);
		send_report(16'h0000, 8'd0, 8'd0, -23170, -23170, 23170, 23170);
		send_report(16'h0000, 8'd0, 8'd0, -23171, 23171, 23171, -23171);

		// random phases over a spread of settings
		program_settings(1'b1, 8'd0, 16'd0, 16'd0);
		run_random(PHASE_ITEMS, -1, -1);
		program_settings(1'b0, 8'd255, 16'd32768, 16'd32768);
		run_random(PHASE_ITEMS, -1, -1);
		program_settings(1'b1, 8'd255, 16'd65535, 16'd1);
		run_random(PHASE_ITEMS, -1, -1);
		// random settings, with the receiver holding off while reports keep coming
		program_settings(1'b1, 8'($urandom), 16'($urandom_range(32768)),
			16'($urandom_range(32768)));
		run_random(PHASE_ITEMS, 20, -1);
		// back to reset values with no idling on either side
		program_settings(1'b0, 8'd30, 16'd7849, 16'd8689);
		idle_on = 1'b0;
		run_random(PHASE_ITEMS, -1, -1);
		idle_on = 1'b1;
		// sender stops mid-phase until the pipeline has emptied
		program_settings(1'b1, 8'd128, 16'd16384, 16'd32768);
		run_random(PHASE_ITEMS, -1, 75);
		program_settings(1'b0, 8'd1, 16'd1, 16'd0);
		run_random(PHASE_ITEMS, -1, -1);

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d reports under %0d register settings, %0d pad conditions checked",
			reports_seen, settings_used, conds_seen);
		$display("with long receiver hold-off, full drain and back-to-back stretch; %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending == 0)
			$display("gamepad_to_console_pad_translate_tb passed");
		else
			$display("gamepad_to_console_pad_translate_tb failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gpct_pkg.sv
rtl/gpct_stick.sv
rtl/gamepad_to_console_pad_translate.sv
verif/gamepad_to_console_pad_translate_checker.sv
verif/gamepad_to_console_pad_translate_tb.sv
